// ----- rtl/core/alfr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// alfr_pkg
// Types, constants and digit decoders for the length-framed receiver.
// ----------------------------------------------------------------------------
package alfr_pkg;

    localparam int MAX_FRAME = 64;                    // position saturates here
    localparam int HDR_LEN   = 4;                     // ASCII length header
    localparam int FLD_LEN   = 7;                     // mode, emerg, backup, errnum
    localparam int POS_W     = $clog2(MAX_FRAME + 1);
    localparam int HDR_IDX_W = $clog2(HDR_LEN);
    localparam int FLD_IDX_W = $clog2(FLD_LEN);
    localparam int DIGIT_W   = 5;
    localparam int NUM_W     = 15;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_0   = 8'h30;
    localparam logic [7:0] CHAR_9   = 8'h39;

    typedef logic [7:0]                t_byte;
    typedef logic [POS_W-1:0]          t_pos;
    typedef logic signed [DIGIT_W-1:0] t_digit;
    typedef logic signed [NUM_W-1:0]   t_num;

    // Single digit: NUL reads as 0, a non-digit as -1.
    function automatic t_digit dec_digit(input t_byte c);
        t_digit r;
        if (c == CHAR_NUL) begin
            r = '0;
        end else if (c < CHAR_0 || c > CHAR_9) begin
            r = '1;
        end else begin
            r = DIGIT_W'(c - CHAR_0);
        end
        return r;
    endfunction

    // Four-digit decimal, first char in s[7:0]. NUL ends it, non-digit gives -1.
    function automatic t_num dec_num4(input logic [31:0] s);
        t_num       acc;
        logic       done;
        logic       bad;
        t_byte      c;
        logic [3:0] d;
        acc  = '0;
        done = 1'b0;
        bad  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            c = s[8*i +: 8];
            d = 4'(c - CHAR_0);
            if (!done) begin
                if (c == CHAR_NUL) begin
                    done = 1'b1;
                end else if (c < CHAR_0 || c > CHAR_9) begin
                    bad  = 1'b1;
                    done = 1'b1;
                end else begin
                    acc = NUM_W'((acc <<< 3) + (acc <<< 1) + t_num'({11'd0, d}));
                end
            end
        end
        return bad ? '1 : acc;
    endfunction

endpackage : alfr_pkg
`default_nettype wire

// ----- rtl/core/alfr_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// alfr_in_if
// Byte channel: one received byte plus its chunk-end flag per word.
// ----------------------------------------------------------------------------
interface alfr_in_if;
    import alfr_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  chunk_end;

    modport source (output valid, output data_byte, output chunk_end, input ready);
    modport sink   (input valid, input data_byte, input chunk_end, output ready);
endinterface : alfr_in_if
`default_nettype wire

// ----- rtl/core/alfr_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// alfr_out_if
// Result channel: decoded frame fields, one word per completed frame.
// ----------------------------------------------------------------------------
interface alfr_out_if;
    import alfr_pkg::*;

    logic   valid;
    logic   ready;
    t_digit mode_value;
    t_digit emergency;
    t_digit feedback_backup;
    t_num   error_number;

    modport source (output valid, output mode_value, output emergency,
                    output feedback_backup, output error_number, input ready);
    modport sink   (input valid, input mode_value, input emergency,
                    input feedback_backup, input error_number, output ready);
endinterface : alfr_out_if
`default_nettype wire

// ----- rtl/core/ascii_length_framed_receiver.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_length_framed_receiver
// Frame receiver for a byte stream with a four-char ASCII decimal length.
// ----------------------------------------------------------------------------
// Takes one byte word per clock on i_in and reports one decoded word on o_res
// for every completed frame. Frame bytes 0..3 hold the decimal frame length
// (header included), bytes 4..6 are single-digit mode, emergency and backup
// feedback fields, bytes 7..10 a four-digit error number. The length is
// parsed when a chunk (bytes up to one with chunk_end set) carries the
// position past the header; a frame completes at a chunk end once the
// position reaches that length. A non-digit yields -1, a NUL ends a digit
// string early; a bad header thus completes at once. A chunk that ends at
// position two without completing is dropped. Stored bytes are never
// cleared, so a short frame reports leftovers of older frames. The position
// saturates at MAX_FRAME, so a longer declared length never completes until
// reset. Throughput is one word per cycle while o_res is not stalled. A word
// passes through the input register, then decode/update into the result
// register. While a result word waits in the result register to be
// taken, the held byte stays in the input register whether or not it yields
// a result, so the input stalls until o_res is drained.
// ----------------------------------------------------------------------------
module ascii_length_framed_receiver (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    alfr_in_if.sink   i_in,
    alfr_out_if.source o_res
);
    import alfr_pkg::*;

    // input register
    logic  r_in_valid;
    t_byte r_in_byte;
    logic  r_in_end;

    // frame state
    t_pos  r_pos,  n_pos;
    t_pos  r_cstart, n_cstart;
    t_num  r_fsize, n_fsize;
    t_byte r_hdr [HDR_LEN];
    t_byte n_hdr [HDR_LEN];
    t_byte r_fld [FLD_LEN];
    t_byte n_fld [FLD_LEN];

    // result register
    logic   r_out_valid;
    t_digit r_mode, r_emerg, r_backup;
    t_num   r_errnum;

    logic   adv;        // result slot free this cycle
    logic   fire;       // stage 2 consumes the held byte
    logic   complete;   // this byte closes a frame
    t_pos   pos_inc;
    logic   have_limit;
    t_num   limit;
    t_num   hdr_val;
    logic signed [NUM_W:0] pos_s;
    logic signed [NUM_W:0] lim_s;

    assign adv        = !r_out_valid || o_res.ready;
    assign fire       = r_in_valid && adv;
    assign i_in.ready = !r_in_valid || adv;

    // ---- input register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_end  <= i_in.chunk_end;
        end
    end

    // ---- decode and state update ----
    always_comb begin
        n_hdr = r_hdr;
        n_fld = r_fld;
        if (r_pos < t_pos'(HDR_LEN)) begin
            n_hdr[r_pos[HDR_IDX_W-1:0]] = r_in_byte;
        end else if (r_pos < t_pos'(HDR_LEN + FLD_LEN)) begin
            n_fld[FLD_IDX_W'(r_pos - t_pos'(HDR_LEN))] = r_in_byte;
        end

        pos_inc = (r_pos < t_pos'(MAX_FRAME)) ? t_pos'(r_pos + 1'b1) : r_pos;
        hdr_val = dec_num4({n_hdr[3], n_hdr[2], n_hdr[1], n_hdr[0]});

        n_fsize    = r_fsize;
        have_limit = 1'b0;
        limit      = r_fsize;
        if (r_in_end) begin
            if (r_cstart < t_pos'(HDR_LEN)) begin
                // chunk started inside the header: parse once it is whole
                if (pos_inc >= t_pos'(HDR_LEN)) begin
                    n_fsize    = hdr_val;
                    limit      = hdr_val;
                    have_limit = 1'b1;
                end
            end else begin
                have_limit = 1'b1;
            end
        end

        pos_s    = $signed({{(NUM_W + 1 - POS_W){1'b0}}, pos_inc});
        lim_s    = $signed({limit[NUM_W-1], limit});
        complete = have_limit && (pos_s >= lim_s);

        n_pos    = pos_inc;
        n_cstart = r_cstart;
        if (r_in_end) begin
            if (complete) begin
                n_pos    = '0;
                n_cstart = '0;
            end else begin
                // chunk ending at two is dropped
                n_pos    = (pos_inc == t_pos'(2)) ? '0 : pos_inc;
                n_cstart = (pos_inc == t_pos'(2)) ? '0 : pos_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_cstart <= '0;
            r_fsize  <= '0;
            for (int i = 0; i < HDR_LEN; i++) begin
                r_hdr[i] <= '0;
            end
            for (int i = 0; i < FLD_LEN; i++) begin
                r_fld[i] <= '0;
            end
        end else if (fire) begin
            r_pos    <= n_pos;
            r_cstart <= n_cstart;
            r_fsize  <= n_fsize;
            r_hdr    <= n_hdr;
            r_fld    <= n_fld;
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= fire && complete;
        end
        if (fire && complete) begin
            r_mode   <= dec_digit(n_fld[0]);
            r_emerg  <= dec_digit(n_fld[1]);
            r_backup <= dec_digit(n_fld[2]);
            r_errnum <= dec_num4({n_fld[6], n_fld[5], n_fld[4], n_fld[3]});
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.mode_value      = r_mode;
    assign o_res.emergency       = r_emerg;
    assign o_res.feedback_backup = r_backup;
    assign o_res.error_number    = r_errnum;

endmodule : ascii_length_framed_receiver
`default_nettype wire

// ----- tb/alfr_rx_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alfr_rx_tb_pkg
// Frame decode predictor and result scoreboard for the length-framed receiver.
// ----------------------------------------------------------------------------
package alfr_rx_tb_pkg;
    import alfr_pkg::*;

    localparam int STORED_LEN = HDR_LEN + FLD_LEN;   // frame bytes kept: 0..10
    localparam int MODE_IDX   = HDR_LEN;
    localparam int EMERG_IDX  = HDR_LEN + 1;
    localparam int BACKUP_IDX = HDR_LEN + 2;
    localparam int ERRNUM_IDX = HDR_LEN + 3;
    localparam int ERRNUM_LEN = 4;
    localparam int MAX_SHOWN  = 10;

    typedef struct packed {
        t_digit mode_value;
        t_digit emergency;
        t_digit feedback_backup;
        t_num   error_number;
    } t_frame_fields;

    class frame_decode_scoreboard;
        int            position;
        int            chunk_start;
        int            frame_len;
        t_byte         frame_bytes[STORED_LEN];
        t_frame_fields expected_frames[$];
        int            errors;

        function new();
            position    = 0;
            chunk_start = 0;
            frame_len   = 0;
            errors      = 0;
            foreach (frame_bytes[i]) frame_bytes[i] = CHAR_NUL;
        endfunction

        // Decimal value of n stored bytes; NUL stops early, non-digit gives -1.
        function int digit_run(int first, int n);
            int    acc;
            t_byte c;
            acc = 0;
            for (int i = 0; i < n; i++) begin
                c = frame_bytes[first + i];
                if (c == CHAR_NUL) break;
                if (c < CHAR_0 || c > CHAR_9) return -1;
                acc = acc * 10 + int'(c - CHAR_0);
            end
            return acc;
        endfunction

        // True when writing c as the next header byte would fix a length
        // beyond the position cap (the receiver would hang until reset).
        function bit header_too_long(t_byte c);
            t_byte saved;
            int    v;
            if (position >= HDR_LEN) return 1'b0;
            if (c != CHAR_NUL && position != HDR_LEN - 1) return 1'b0;
            saved                 = frame_bytes[position];
            frame_bytes[position] = c;
            v                     = digit_run(0, position + 1);
            frame_bytes[position] = saved;
            return v > MAX_FRAME;
        endfunction

        function void note_byte(t_byte b, bit last);
            bit            have_limit;
            int            limit;
            t_frame_fields f;
            if (position < STORED_LEN) frame_bytes[position] = b;
            if (position < MAX_FRAME) position++;
            if (!last) return;

            have_limit = 1'b0;
            limit      = 0;
            if (chunk_start < HDR_LEN) begin
                // header parsed only when this chunk crosses it
                if (position >= HDR_LEN) begin
                    frame_len  = digit_run(0, HDR_LEN);
                    limit      = frame_len;
                    have_limit = 1'b1;
                end
            end else begin
                limit      = frame_len;
                have_limit = 1'b1;
            end

            if (have_limit && position >= limit) begin
                f.mode_value      = t_digit'(digit_run(MODE_IDX, 1));
                f.emergency       = t_digit'(digit_run(EMERG_IDX, 1));
                f.feedback_backup = t_digit'(digit_run(BACKUP_IDX, 1));
                f.error_number    = t_num'(digit_run(ERRNUM_IDX, ERRNUM_LEN));
                expected_frames.push_back(f);
                position    = 0;
                chunk_start = 0;
                return;
            end

            if (position == 2) position = 0;  // short chunk dropped
            chunk_start = position;
        endfunction

        function void check_frame(t_frame_fields got);
            t_frame_fields want;
            if (expected_frames.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected word: mode %0d emerg %0d backup %0d errnum %0d",
                             got.mode_value, got.emergency, got.feedback_backup,
                             got.error_number);
                return;
            end
            want = expected_frames.pop_front();
            if (got.mode_value !== want.mode_value || got.emergency !== want.emergency ||
                got.feedback_backup !== want.feedback_backup ||
                got.error_number !== want.error_number) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             want.mode_value, want.emergency, want.feedback_backup,
                             want.error_number, got.mode_value, got.emergency,
                             got.feedback_backup, got.error_number);
            end
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

endpackage : alfr_rx_tb_pkg

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ASCII length-framed receiver.
// ----------------------------------------------------------------------------
// Drives the byte channel with a short directed set, then mostly well-formed
// frames with random lengths, header forms and field bytes, mixed with noise
// runs and broken chunks. Every accepted word updates a predictor that queues
// the decoded fields of each frame it sees complete; result words are checked
// in order against that queue. Both sides idle in random bursts, and the
// result side once holds off long enough to back the block up. The run ends
// by driving the receiver into its saturated state with an oversize length.
// ----------------------------------------------------------------------------
module testbench;
    import alfr_pkg::*;
    import alfr_rx_tb_pkg::*;

    localparam int         ITEMS        = 850;
    localparam int         TAIL_WORDS   = 84;      // oversize length plus saturation run
    localparam int         QUIET_ITEMS  = 100;     // tail of the run without idling
    localparam int         HOLD_AT      = 250;     // word count that starts the long hold
    localparam int         HOLD_CYCLES  = 400;
    localparam int         DRAIN_CYCLES = 20;      // drain slack after the last expected result
    localparam int         CYCLE_LIMIT  = 300000;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;   // just below '0'
    localparam logic [7:0] CHAR_COLON   = 8'h3A;   // just above '9'

    logic i_clk;
    logic i_rst_n;

    alfr_in_if  in_ch ();
    alfr_out_if res_ch ();

    ascii_length_framed_receiver DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    frame_decode_scoreboard sb;
    int words_sent  = 0;
    int gap_level   = 0;    // 0: no sender gaps, 1: rare, 2: frequent
    bit quiet       = 1'b0; // set for the tail: no idling on either side
    bit held_off    = 1'b0;
    int cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result monitor: a word moves when valid and ready meet at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            sb.check_frame(t_frame_fields'{mode_value:      res_ch.mode_value,
                                           emergency:       res_ch.emergency,
                                           feedback_backup: res_ch.feedback_backup,
                                           error_number:    res_ch.error_number});
        end
    end

    // Result-side flow control: random ready bursts, plus one long hold-off
    // while the sender keeps pushing so the result register backs up.
    initial begin
        res_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!held_off && words_sent >= HOLD_AT) begin
                held_off = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (quiet || $urandom_range(0, 2) != 0) begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    // One word on the byte channel; returns at the accepting edge with
    // valid still high so back-to-back words need no extra cycle.
    task automatic send_word(input t_byte b, input bit last);
        if (gap_level != 0 && $urandom_range(0, (gap_level == 1) ? 15 : 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.chunk_end <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_byte(b, last);
        words_sent++;
    endtask

    task automatic send_run(input string s, input bit end_on_last);
        for (int i = 0; i < s.len(); i++)
            send_word(t_byte'(s[i]), end_on_last && (i == s.len() - 1));
    endtask

    // Bring the frame position back to zero. Below the header, '/' fill
    // makes the length -1 (or a small value ended by an earlier NUL);
    // past it, single-byte chunks walk up to the stored length.
    task automatic realign();
        while (sb.position != 0) begin
            if (sb.position < HDR_LEN)
                send_word(CHAR_SLASH, sb.position == HDR_LEN - 1);
            else
                send_word(t_byte'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic send_frame();
        t_byte fb[STORED_LEN];
        int    len;
        int    n;
        int    pick;
        t_byte b;
        bit    last;
        realign();
        pick = $urandom_range(0, 19);
        if (pick < 2)       len = $urandom_range(0, 10);          // short: stale fields
        else if (pick == 2) len = $urandom_range(50, MAX_FRAME);  // up to the cap
        else                len = $urandom_range(11, 30);

        if ($urandom_range(0, 5) == 0) begin
            // NUL-terminated length, trailing bytes are don't-care
            fb[2] = t_byte'($urandom_range(0, 255));
            fb[3] = t_byte'($urandom_range(0, 255));
            if (len >= 10) begin
                fb[0] = CHAR_0 + t_byte'(len / 10);
                fb[1] = CHAR_0 + t_byte'(len % 10);
                fb[2] = CHAR_NUL;
            end else if (len == 0 && $urandom_range(0, 1) == 1) begin
                fb[0] = CHAR_NUL;                       // empty string reads as 0
            end else begin
                fb[0] = CHAR_0 + t_byte'(len);
                fb[1] = CHAR_NUL;
            end
        end else begin
            fb[0] = CHAR_0;
            fb[1] = CHAR_0;
            fb[2] = CHAR_0 + t_byte'(len / 10);
            fb[3] = CHAR_0 + t_byte'(len % 10);
        end

        for (int i = HDR_LEN; i < STORED_LEN; i++) begin
            pick = $urandom_range(0, 11);
            if (pick == 0)      fb[i] = CHAR_NUL;
            else if (pick == 1) fb[i] = t_byte'($urandom_range(0, 255));
            else if (pick == 2) fb[i] = ($urandom_range(0, 1) == 1) ? CHAR_SLASH : CHAR_COLON;
            else                fb[i] = CHAR_0 + t_byte'($urandom_range(0, 9));
        end

        n = (len < HDR_LEN) ? HDR_LEN : len;
        for (int i = 0; i < n; i++) begin
            b = (i < STORED_LEN) ? fb[i] : t_byte'($urandom_range(0, 255));
            // split into random chunks, never ending one at position two
            last = (i == n - 1) || (i != 1 && $urandom_range(0, 3) == 0);
            send_word(b, last);
        end
    endtask

    // Unframed bytes and broken chunks; header bytes that would lock the
    // block on an oversize length are swapped for a non-digit.
    task automatic send_noise();
        int    k;
        int    pick;
        t_byte b;
        k = $urandom_range(1, 16);
        repeat (k) begin
            pick = $urandom_range(0, 5);
            if (pick < 2)       b = t_byte'($urandom_range(0, 255));
            else if (pick < 4)  b = CHAR_0 + t_byte'($urandom_range(0, 9));
            else if (pick == 4) b = CHAR_NUL;
            else                b = ($urandom_range(0, 1) == 1) ? CHAR_SLASH : CHAR_COLON;
            if (sb.header_too_long(b)) b = CHAR_SLASH;
            send_word(b, $urandom_range(0, 2) == 0);
        end
    endtask

    initial begin
        sb = new();
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.chunk_end <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full frame with extreme digits and errnum 9999
        gap_level = 1;
        send_run("00119099999", 1'b1);
        // chunk ending at position two is dropped
        send_run("00", 1'b1);
        // bad header: length -1, completes at once with stale fields
        send_run("1a22", 1'b1);
        // NUL-terminated length 5: no completion at 4, NUL field reads as 0
        send_word("5", 1'b0);
        send_word(CHAR_NUL, 1'b0);
        send_word(CHAR_NUL, 1'b0);
        send_word(CHAR_NUL, 1'b1);
        send_word(CHAR_NUL, 1'b1);

        // Random frames and noise
        while (words_sent < ITEMS - TAIL_WORDS) begin
            if (!quiet && words_sent >= ITEMS - QUIET_ITEMS) quiet = 1'b1;
            gap_level = quiet ? 0 : $urandom_range(0, 2);
            if ($urandom_range(0, 3) != 0) send_frame();
            else                           send_noise();
        end

        // Oversize length: position saturates at the cap and the frame
        // never completes, so nothing more may come out.
        quiet     = 1'b1;
        gap_level = 0;
        realign();
        send_run("0099", 1'b1);
        repeat (80) send_word(t_byte'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule : testbench
